// File: design/apt_pkg.sv
package apt_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int NUM_ROWS   = 3;
  localparam int NUM_COLS   = 4;
  localparam int NUM_COEFS  = NUM_ROWS * NUM_COLS;
  localparam int IDX_WIDTH  = 4;

  // full product and exact four-term sum widths
  localparam int PROD_WIDTH = 2 * DATA_WIDTH;
  localparam int SUM_WIDTH  = PROD_WIDTH + 2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_POINT = 1'b1;

  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic signed [PROD_WIDTH-1:0] prod_t;
  typedef logic signed [SUM_WIDTH-1:0]  sum_t;

  localparam word_t MAX_VAL  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam word_t MIN_VAL  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam word_t COEF_ONE = DATA_WIDTH'(64'd1 << FRAC_BITS);
  localparam word_t COEF_ZERO = '0;

endpackage

// File: design/affine_point_transform.sv
// Homogeneous point transform (top three rows of a 4x4 matrix), Q16.16.
// An accepted point transaction passes through the four pipeline registers (stages 1 to 4) to the output.
// Throughput: one transaction per cycle while the output is not stalled; the four pipeline registers each hold a slot.
// Load transactions write the coefficient bank at acceptance and produce no output.
// Reset (async, active low) empties the pipeline and loads the identity matrix.
module affine_point_transform (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         opcode_i,
  input  logic [apt_pkg::IDX_WIDTH-1:0] coef_index_i,
  input  apt_pkg::word_t               coef_value_i,
  input  apt_pkg::word_t               in_x_i,
  input  apt_pkg::word_t               in_y_i,
  input  apt_pkg::word_t               in_z_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output apt_pkg::word_t               out_x_o,
  output apt_pkg::word_t               out_y_o,
  output apt_pkg::word_t               out_z_o,
  output logic                         saturated_o
);
  import apt_pkg::*;

  localparam int NUM_STAGES = 4;

  // ---------------------------------------------------------------------------
  // Handshake: each stage advances when it is empty or the next one moves.
  // ---------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES-1:0] adv;

  always_comb begin
    adv[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || !out_stall_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign in_stall_o = !adv[0];

  logic in_acc;
  logic load_acc;
  logic point_acc;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign load_acc  = in_acc && (opcode_i == OP_LOAD);
  assign point_acc = in_acc && (opcode_i == OP_POINT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= point_acc;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Coefficient bank, twelve words at fixed positions, reset to identity.
  // A load out of range (index 12..15) is dropped.
  // ---------------------------------------------------------------------------
  word_t coef_q [NUM_COEFS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEFS; i++) begin
        coef_q[i] <= ((i % (NUM_COLS + 1)) == 0) ? COEF_ONE : COEF_ZERO;
      end
    end else if (load_acc && (coef_index_i < IDX_WIDTH'(NUM_COEFS))) begin
      coef_q[coef_index_i] <= coef_value_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: nine 32x32 products straight off the input, plus translations.
  // Coefficients are sampled here, so later loads never touch items in flight.
  // ---------------------------------------------------------------------------
  word_t pt [NUM_ROWS];
  assign pt[0] = in_x_i;
  assign pt[1] = in_y_i;
  assign pt[2] = in_z_i;

  prod_t prod_d [NUM_ROWS][NUM_ROWS];
  prod_t prod_q [NUM_ROWS][NUM_ROWS];
  word_t tr_q   [NUM_ROWS];

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_ROWS; c++) begin
        prod_d[r][c] = PROD_WIDTH'(coef_q[r*NUM_COLS+c]) * PROD_WIDTH'(pt[c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        tr_q[r] <= coef_q[r*NUM_COLS+NUM_COLS-1];
        for (int c = 0; c < NUM_ROWS; c++) begin
          prod_q[r][c] <= prod_d[r][c];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: arithmetic shift (floor) by the fraction bits, pairwise adds.
  // Stage 3: final exact sum per row.
  // ---------------------------------------------------------------------------
  sum_t pa_q [NUM_ROWS];
  sum_t pb_q [NUM_ROWS];
  sum_t sum_q [NUM_ROWS];

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        pa_q[r] <= SUM_WIDTH'(prod_q[r][0] >>> FRAC_BITS)
                 + SUM_WIDTH'(prod_q[r][1] >>> FRAC_BITS);
        pb_q[r] <= SUM_WIDTH'(prod_q[r][2] >>> FRAC_BITS) + SUM_WIDTH'(tr_q[r]);
      end
    end
    if (adv[2]) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        sum_q[r] <= pa_q[r] + pb_q[r];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: clamp to the word range; this is the output register.
  // ---------------------------------------------------------------------------
  word_t               res_d [NUM_ROWS];
  logic [NUM_ROWS-1:0] clip_d;
  word_t               res_q [NUM_ROWS];
  logic                sat_q;

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      priority if (sum_q[r] > SUM_WIDTH'(MAX_VAL)) begin
        res_d[r]  = MAX_VAL;
        clip_d[r] = 1'b1;
      end else if (sum_q[r] < SUM_WIDTH'(MIN_VAL)) begin
        res_d[r]  = MIN_VAL;
        clip_d[r] = 1'b1;
      end else begin
        res_d[r]  = sum_q[r][DATA_WIDTH-1:0];
        clip_d[r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        res_q[r] <= res_d[r];
      end
      sat_q <= |clip_d;
    end
  end

  assign out_valid_o = vld_q[NUM_STAGES-1];
  assign out_x_o     = res_q[0];
  assign out_y_o     = res_q[1];
  assign out_z_o     = res_q[2];
  assign saturated_o = sat_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Input back-pressure only when every stage is occupied and the output is held.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q) && out_stall_i)
    else $error("input stalled while pipeline has a free slot");

  // An in-range load lands in the bank on the next cycle.
  a_load_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_acc && (coef_index_i < IDX_WIDTH'(NUM_COEFS))
    |=> coef_q[$past(coef_index_i)] == $past(coef_value_i))
    else $error("coefficient load not stored");

  // An accepted point occupies stage one on the next cycle.
  a_point_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_acc |=> vld_q[0])
    else $error("accepted point lost at pipeline entry");

  // A blocked stage three implies a held, valid result in the output register.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NUM_STAGES-2] && !adv[NUM_STAGES-2] |=> vld_q[NUM_STAGES-1])
    else $error("stage three blocked without a full output register");

endmodule
